/* src/bpk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bpk_pkg: shared types and constants of the MSB-first bit packer
// Item structs for both channels, the command passed from the front to the
// back, and the sizing constants of the block.
// ============================================================================
package bpk_pkg;

    // Widest field that a write may carry; counts above it are rejected.
    localparam int MAX_FIELD_BITS = 64;
    // Fixed width of the field_value port.
    localparam int FIELD_W        = 64;
    localparam int COUNT_W        = 7;
    localparam int BYTE_W         = 8;
    localparam int POS_W          = 3;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Input operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ALIGN = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ALIGN = 2'd1,
        CMD_BAD   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic                 op;
        logic [FIELD_W-1:0]   field_value;
        logic [COUNT_W-1:0]   bit_count;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    byte_out;
        logic                 has_byte;
        logic                 bad_count;
        logic                 last;
    } out_item_t;

    // Field bits are stored left aligned: the first bit to send is bit 63,
    // and every bit below the field is zero.
    typedef struct packed {
        cmd_kind_t            kind;
        logic [FIELD_W-1:0]   bits;
        logic [COUNT_W-1:0]   count;
    } cmd_t;

endpackage
`default_nettype wire

/* src/bpk_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bpk_front: input stage of the bit packer
// Accepts input transfers, sorts them into write, align and bad-count
// commands, and left aligns the field bits for the back end.
// ============================================================================
module bpk_front
    import bpk_pkg::*;
(
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    input  wire logic     queue_full,
    output logic          push,
    output cmd_t          cmd
);

    logic [COUNT_W-1:0] shift_amt;
    logic               count_bad;

    assign in_ready  = !queue_full;
    assign push      = in_valid && in_ready;

    assign count_bad = (in_data.bit_count == '0)
                    || (in_data.bit_count > COUNT_W'(MAX_FIELD_BITS));
    // Shifting left by (64 - count) drops the unused upper bits as well.
    assign shift_amt = COUNT_W'(FIELD_W) - in_data.bit_count;

    always_comb
    begin
        cmd.bits  = '0;
        cmd.count = in_data.bit_count;
        if (in_data.op == OP_ALIGN)
        begin
            cmd.kind = CMD_ALIGN;
        end
        else if (count_bad)
        begin
            cmd.kind = CMD_BAD;
        end
        else
        begin
            cmd.kind = CMD_WRITE;
            cmd.bits = in_data.field_value << shift_amt[$clog2(FIELD_W)-1:0];
        end
    end

endmodule
`default_nettype wire

/* src/bpk_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bpk_queue: command queue between front and back
// A small register FIFO that lets the front keep accepting while the back
// drains bytes of a long field.
// ============================================================================
module bpk_queue
    import bpk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

/* src/bpk_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bpk_back: execution stage of the bit packer
// Holds the partial byte, works through one command at a time and emits
// every completed byte through a registered output.
// ============================================================================
module bpk_back
    import bpk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    // Packing state.
    logic [BYTE_W-1:0]  pb_reg, pb_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    // Command in progress.
    logic               cur_valid_reg;
    cmd_kind_t          cur_kind_reg;
    logic [FIELD_W-1:0] fv_reg, fv_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;

    // Output register.
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [COUNT_W-1:0] avail;
    logic [POS_W:0]     take;
    logic [COUNT_W-1:0] rem_after;
    logic [FIELD_W-1:0] fv_shifted;
    logic [BYTE_W-1:0]  top_bits;
    logic               need_emit;
    logic               finish;
    out_item_t          emit_item;
    logic               emit_ok;
    logic               step;

    assign avail      = COUNT_W'(pos_reg) + rem_reg;
    assign take       = (POS_W + 1)'(BYTE_W) - {1'b0, pos_reg};
    assign rem_after  = rem_reg - COUNT_W'(take);
    assign fv_shifted = fv_reg << take;
    assign top_bits   = fv_reg[FIELD_W-1 -: BYTE_W] >> pos_reg;

    always_comb
    begin
        need_emit = 1'b0;
        finish    = 1'b0;
        emit_item = '0;
        pb_next   = pb_reg;
        pos_next  = pos_reg;
        fv_next   = fv_reg;
        rem_next  = rem_reg;
        case (cur_kind_reg)
            CMD_WRITE:
            begin
                if (avail >= COUNT_W'(BYTE_W))
                begin
                    need_emit          = 1'b1;
                    emit_item.byte_out = pb_reg | top_bits;
                    emit_item.has_byte = 1'b1;
                    emit_item.last     = (rem_after < COUNT_W'(BYTE_W));
                    if (emit_item.last)
                    begin
                        // The leftover bits start the next byte.
                        finish   = 1'b1;
                        pb_next  = fv_shifted[FIELD_W-1 -: BYTE_W];
                        pos_next = rem_after[POS_W-1:0];
                    end
                    else
                    begin
                        pb_next  = '0;
                        pos_next = '0;
                        fv_next  = fv_shifted;
                        rem_next = rem_after;
                    end
                end
                else
                begin
                    finish   = 1'b1;
                    pb_next  = pb_reg | top_bits;
                    pos_next = avail[POS_W-1:0];
                end
            end
            CMD_ALIGN:
            begin
                finish = 1'b1;
                if (pos_reg != '0)
                begin
                    need_emit          = 1'b1;
                    emit_item.byte_out = pb_reg;
                    emit_item.has_byte = 1'b1;
                    emit_item.last     = 1'b1;
                    pb_next            = '0;
                    pos_next           = '0;
                end
            end
            CMD_BAD:
            begin
                finish              = 1'b1;
                need_emit           = 1'b1;
                emit_item.bad_count = 1'b1;
                emit_item.last      = 1'b1;
            end
            default:
            begin
                finish = 1'b1;
            end
        endcase
    end

    assign emit_ok = !out_valid_reg || out_ready;
    assign step    = cur_valid_reg && (!need_emit || emit_ok);
    assign pop     = head_valid && (!cur_valid_reg || (step && finish));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pb_reg        <= '0;
            pos_reg       <= '0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                pb_reg  <= pb_next;
                pos_reg <= pos_next;
            end
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (step && finish)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (step && need_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_kind_reg <= head_cmd.kind;
            fv_reg       <= head_cmd.bits;
            rem_reg      <= head_cmd.count;
        end
        else if (step)
        begin
            fv_reg  <= fv_next;
            rem_reg <= rem_next;
        end
        if (step && need_emit)
        begin
            out_data_reg <= emit_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Bits of the partial byte below the fill position are always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pb_reg & (8'hFF >> pos_reg)) == '0)
        else $error("partial byte has bits below the fill position");

    // A bad-count result never carries a byte and always closes its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.bad_count |->
            !out_data_reg.has_byte && out_data_reg.last)
        else $error("bad-count result is malformed");

    // A write in progress always has between 1 and the maximum bits left.
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && (cur_kind_reg == CMD_WRITE) |->
            (rem_reg != '0) && (rem_reg <= COUNT_W'(MAX_FIELD_BITS)))
        else $error("write command holds an impossible bit count");

    // A byte that is not the last of its write leaves the same write active
    // with an empty partial byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && need_emit && !emit_item.last |=>
            cur_valid_reg && (pos_reg == '0) && (cur_kind_reg == CMD_WRITE))
        else $error("write lost its place after a middle byte");

    // A command only finishes on a cycle that emits nothing or emits its last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && finish |-> !need_emit || emit_item.last)
        else $error("command finished on a byte not marked last");

endmodule
`default_nettype wire

/* src/msb_first_bit_packer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// msb_first_bit_packer: MSB-first variable-length bit packer
// Packs fields of 1 to 64 bits into a byte stream, first bit in bit 7.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one transfer per
//   item: a write appends the low bit_count bits of field_value, an align
//   pads the partial byte with zeros and sends it if any bits are pending.
//   A write with bit_count of 0 or above 64 returns one result with
//   bad_count set and leaves the packing state alone.
//   The output channel (out_valid/out_ready/out_data) carries one transfer
//   per result; last marks the final result of an item. Writes and aligns that
//   complete no byte give no result.
//   An item passes through the command queue, the back end's command
//   register and the output register before its first result. Throughput:
//   one item per cycle while each yields at most one result and the output
//   is not stalled; a write that completes more than one byte holds the
//   back end while its bytes drain, one per cycle while out_ready is high;
//   a two-entry command queue between them keeps the input open meanwhile.
//   Reset clears the partial byte, the bit position, the queue and the
//   output valid flag. When the receiver stalls, the output register holds
//   its result, the back end waits, and the input stays ready until the
//   queue fills.
// ============================================================================
module msb_first_bit_packer
    import bpk_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic queue_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Front: accepts transfers and turns them into commands.
    bpk_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Queue: decouples the front from the back.
    bpk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back: owns the partial byte and emits completed bytes.
    bpk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire
